FILE: hw/rtl/csvlex_pkg.sv
// Shared types, character codes and style codes of the CSV style lexer.
`timescale 1ns / 1ps

package csvlex_pkg;

   // Field widths
   localparam int LEN_W   = 25;
   localparam int STYLE_W = 3;

   // Default sizing
   localparam int DEF_MAX_REGION_BYTES = 16777216;
   localparam int DEF_QUEUE_DEPTH      = 4;

   // Results one input byte can cause at most, and the derived widths
   localparam int RES_SLOTS = 2;
   localparam int SLOT_W    = $clog2(RES_SLOTS);
   localparam int RCNT_W    = $clog2(RES_SLOTS + 1);

   // Configuration register indexes
   localparam logic CSR_SEPARATOR_CHAR = 1'b0;
   localparam logic CSR_REGION_DOC     = 1'b1;

   // Reset values of the configuration registers
   localparam logic [7:0] DEF_SEPARATOR  = 8'h2C;
   localparam logic       DEF_REGION_DOC = 1'b1;

   // Character codes
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Style codes
   localparam logic [STYLE_W-1:0] STYLE_DEFAULT  = 3'd0;
   localparam logic [STYLE_W-1:0] STYLE_HEADER   = 3'd1;
   localparam logic [STYLE_W-1:0] STYLE_COL_EVEN = 3'd2;
   localparam logic [STYLE_W-1:0] STYLE_COL_ODD  = 3'd3;
   localparam logic [STYLE_W-1:0] STYLE_SEP      = 3'd4;
   localparam logic [STYLE_W-1:0] STYLE_QUOTED   = 3'd5;
   localparam logic [STYLE_W-1:0] STYLE_NUMBER   = 3'd6;
   localparam logic [STYLE_W-1:0] STYLE_COMMENT  = 3'd7;

   // One input item
   typedef struct packed {
      logic [7:0] text_byte;
      logic       region_end;
   } req_type;

   // One result item
   typedef struct packed {
      logic [LEN_W-1:0]   run_length;
      logic [STYLE_W-1:0] style_code;
      logic               run_last;
   } rsp_type;

   // All results caused by one input byte, oldest in slot 0
   typedef struct packed {
      logic [RCNT_W-1:0]           count;
      rsp_type [RES_SLOTS-1:0]     slot;
   } bundle_type;

   // Queue status toward both neighbors
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hw/rtl/csvlex_front.sv
// Front part: configuration registers and the byte classifier that builds result bundles.
`timescale 1ns / 1ps

module csvlex_front import csvlex_pkg::*; #(
   parameter int MAX_REGION_BYTES = DEF_MAX_REGION_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output logic       bundle_valid,
   output bundle_type bundle
);

   localparam int CW = $clog2(MAX_REGION_BYTES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGION_BYTES);

   typedef enum logic [2:0] {
      MODE_LINE,
      MODE_CELL,
      MODE_QUOTE,
      MODE_QEND,
      MODE_COMMENT,
      MODE_CR
   } mode_type;

   typedef enum logic [2:0] {
      NUM_LEAD,
      NUM_SIGN,
      NUM_BODY,
      NUM_TRAIL,
      NUM_FAIL
   } num_type;

   mode_type    mode_ff, mode_in;
   num_type     num_ff, num_in;
   logic        hdr_ff, hdr_in;
   logic        par_ff, par_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]  seen_ff, seen_in;
   logic        fresh_ff;
   logic [7:0]  sep_ff;
   logic        doc_ff;

   rsp_type [RES_SLOTS-1:0] res_c;
   logic [RCNT_W-1:0]       n_c;

   // Widen or cut a run count to the result field
   function automatic logic [LEN_W-1:0] to_len(input logic [CW-1:0] v);
      logic [CW+LEN_W-1:0] wide;
      wide = {{LEN_W{1'b0}}, v};
      return wide[LEN_W-1:0];
   endfunction

   // Style of a plain cell at its end
   function automatic logic [STYLE_W-1:0] cell_style(input logic hdr, input num_type np,
                                                     input logic [1:0] sd, input logic par);
      if (hdr) begin
         return STYLE_HEADER;
      end else if ((np == NUM_BODY || np == NUM_TRAIL) && sd[0]) begin
         return STYLE_NUMBER;
      end else begin
         return par ? STYLE_COL_ODD : STYLE_COL_EVEN;
      end
   endfunction

   // Classify one byte and collect the runs it closes
   always_comb begin
      logic [7:0]        c;
      logic              done;
      logic              ws;
      logic              dig;
      logic              body_step;
      logic [RCNT_W-1:0] n_last;

      c         = req_data.text_byte;
      done      = 1'b0;
      ws        = (c == CHAR_SPACE) || (c == CHAR_TAB);
      dig       = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      body_step = 1'b0;
      n_last    = '0;

      mode_in = mode_ff;
      num_in  = num_ff;
      hdr_in  = hdr_ff;
      par_in  = par_ff;
      cnt_in  = cnt_ff;
      seen_in = seen_ff;
      res_c   = '0;
      n_c     = '0;

      // Inside a quote, or just past a quote that may be doubled
      if (mode_in == MODE_QUOTE) begin
         if (cnt_in < CNT_MAX) cnt_in = cnt_in + CW'(1);
         if (c == CHAR_QUOTE) mode_in = MODE_QEND;
         done = 1'b1;
      end else if (mode_in == MODE_QEND) begin
         if (c == CHAR_QUOTE) begin
            if (cnt_in < CNT_MAX) cnt_in = cnt_in + CW'(1);
            mode_in = MODE_QUOTE;
            done    = 1'b1;
         end else begin
            res_c[n_c[SLOT_W-1:0]] = '{run_length: to_len(cnt_in),
                                       style_code: STYLE_QUOTED, run_last: 1'b0};
            n_c     = n_c + RCNT_W'(1);
            cnt_in  = '0;
            num_in  = NUM_LEAD;
            seen_in = '0;
            mode_in = MODE_CELL;
         end
      end

      // Comment line runs to CR or LF
      if (!done && mode_in == MODE_COMMENT) begin
         if (c == CHAR_LF || c == CHAR_CR) begin
            res_c[n_c[SLOT_W-1:0]] = '{run_length: to_len(cnt_in),
                                       style_code: STYLE_COMMENT, run_last: 1'b0};
            n_c     = n_c + RCNT_W'(1);
            hdr_in  = 1'b0;
            par_in  = 1'b0;
            cnt_in  = '0;
            num_in  = NUM_LEAD;
            seen_in = '0;
            if (c == CHAR_LF) begin
               res_c[n_c[SLOT_W-1:0]] = '{run_length: LEN_W'(1),
                                          style_code: STYLE_DEFAULT, run_last: 1'b0};
               n_c     = n_c + RCNT_W'(1);
               mode_in = MODE_LINE;
            end else begin
               mode_in = MODE_CR;
            end
         end else begin
            if (cnt_in < CNT_MAX) cnt_in = cnt_in + CW'(1);
         end
         done = 1'b1;
      end

      // Pending CR: merge a following LF, else close it alone
      if (!done && mode_in == MODE_CR) begin
         if (c == CHAR_LF) begin
            res_c[n_c[SLOT_W-1:0]] = '{run_length: LEN_W'(2),
                                       style_code: STYLE_DEFAULT, run_last: 1'b0};
            n_c  = n_c + RCNT_W'(1);
            done = 1'b1;
         end else begin
            res_c[n_c[SLOT_W-1:0]] = '{run_length: LEN_W'(1),
                                       style_code: STYLE_DEFAULT, run_last: 1'b0};
            n_c = n_c + RCNT_W'(1);
         end
         mode_in = MODE_LINE;
      end

      // Hash at line start opens a comment
      if (!done && mode_in == MODE_LINE && c == CHAR_HASH) begin
         mode_in = MODE_COMMENT;
         cnt_in  = CW'(1);
         done    = 1'b1;
      end

      if (!done) begin
         // Close the open plain cell before any delimiter
         if (c == CHAR_QUOTE || c == sep_ff || c == CHAR_LF || c == CHAR_CR) begin
            if (cnt_in != '0) begin
               res_c[n_c[SLOT_W-1:0]] = '{run_length: to_len(cnt_in),
                  style_code: cell_style(hdr_in, num_in, seen_in, par_in), run_last: 1'b0};
               n_c = n_c + RCNT_W'(1);
            end
            cnt_in  = '0;
            num_in  = NUM_LEAD;
            seen_in = '0;
         end

         if (c == CHAR_QUOTE) begin
            cnt_in  = CW'(1);
            mode_in = MODE_QUOTE;
         end else if (c == sep_ff) begin
            res_c[n_c[SLOT_W-1:0]] = '{run_length: LEN_W'(1),
                                       style_code: STYLE_SEP, run_last: 1'b0};
            n_c    = n_c + RCNT_W'(1);
            par_in = ~par_in;
            if (!(mode_in == MODE_LINE && (c == CHAR_LF || c == CHAR_CR))) begin
               mode_in = MODE_CELL;
            end
         end else if (c == CHAR_LF) begin
            res_c[n_c[SLOT_W-1:0]] = '{run_length: LEN_W'(1),
                                       style_code: STYLE_DEFAULT, run_last: 1'b0};
            n_c     = n_c + RCNT_W'(1);
            hdr_in  = 1'b0;
            par_in  = 1'b0;
            mode_in = MODE_LINE;
         end else if (c == CHAR_CR) begin
            hdr_in  = 1'b0;
            par_in  = 1'b0;
            mode_in = MODE_CR;
         end else begin
            // Plain cell byte: count it and advance the number check
            if (cnt_in < CNT_MAX) cnt_in = cnt_in + CW'(1);
            case (num_in)
               NUM_LEAD: begin
                  if (ws) begin
                     num_in = NUM_LEAD;
                  end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                     num_in = NUM_SIGN;
                  end else begin
                     body_step = 1'b1;
                  end
               end
               NUM_SIGN, NUM_BODY: begin
                  body_step = 1'b1;
               end
               NUM_TRAIL: begin
                  if (!ws) num_in = NUM_FAIL;
               end
               default: begin
                  num_in = NUM_FAIL;
               end
            endcase
            if (body_step) begin
               if (dig) begin
                  seen_in[0] = 1'b1;
                  num_in     = NUM_BODY;
               end else if (c == CHAR_DOT && !seen_in[1]) begin
                  seen_in[1] = 1'b1;
                  num_in     = NUM_BODY;
               end else if (ws && num_in == NUM_BODY) begin
                  num_in = NUM_TRAIL;
               end else begin
                  num_in = NUM_FAIL;
               end
            end
            mode_in = MODE_CELL;
         end
      end

      // Region end: flush what is open, mark the final run, restart
      if (req_data.region_end) begin
         case (mode_in)
            MODE_QUOTE, MODE_QEND: begin
               if (cnt_in != '0) begin
                  res_c[n_c[SLOT_W-1:0]] = '{run_length: to_len(cnt_in),
                                             style_code: STYLE_QUOTED, run_last: 1'b0};
                  n_c = n_c + RCNT_W'(1);
               end
            end
            MODE_COMMENT: begin
               if (cnt_in != '0) begin
                  res_c[n_c[SLOT_W-1:0]] = '{run_length: to_len(cnt_in),
                                             style_code: STYLE_COMMENT, run_last: 1'b0};
                  n_c = n_c + RCNT_W'(1);
               end
            end
            MODE_CR: begin
               res_c[n_c[SLOT_W-1:0]] = '{run_length: LEN_W'(1),
                                          style_code: STYLE_DEFAULT, run_last: 1'b0};
               n_c = n_c + RCNT_W'(1);
            end
            default: begin
               if (cnt_in != '0) begin
                  res_c[n_c[SLOT_W-1:0]] = '{run_length: to_len(cnt_in),
                     style_code: cell_style(hdr_in, num_in, seen_in, par_in), run_last: 1'b0};
                  n_c = n_c + RCNT_W'(1);
               end
            end
         endcase
         if (n_c != '0) begin
            n_last = n_c - RCNT_W'(1);
            res_c[n_last[SLOT_W-1:0]].run_last = 1'b1;
         end
         mode_in = MODE_LINE;
         hdr_in  = doc_ff;
         par_in  = 1'b0;
         cnt_in  = '0;
         num_in  = NUM_LEAD;
         seen_in = '0;
      end
   end

   assign bundle_valid = accept && (n_c != '0);
   assign bundle.count = n_c;
   assign bundle.slot  = res_c;

   // Hold scanner state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_LINE;
         num_ff   <= NUM_LEAD;
         hdr_ff   <= DEF_REGION_DOC;
         par_ff   <= 1'b0;
         cnt_ff   <= '0;
         seen_ff  <= '0;
         fresh_ff <= 1'b1;
         sep_ff   <= DEF_SEPARATOR;
         doc_ff   <= DEF_REGION_DOC;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            num_ff   <= num_in;
            hdr_ff   <= hdr_in;
            par_ff   <= par_in;
            cnt_ff   <= cnt_in;
            seen_ff  <= seen_in;
            fresh_ff <= req_data.region_end;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SEPARATOR_CHAR: begin
                  sep_ff <= csr_wdata;
               end
               CSR_REGION_DOC: begin
                  doc_ff <= csr_wdata[0];
                  if (fresh_ff) hdr_ff <= csr_wdata[0];
               end
               default: begin
                  sep_ff <= sep_ff;
               end
            endcase
         end
      end
   end

endmodule

FILE: hw/rtl/csvlex_fifo.sv
// Short queue of result bundles between the front and back parts.
`timescale 1ns / 1ps

module csvlex_fifo import csvlex_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_data,
   input  logic             pop,
   output bundle_type       head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bundle_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push_ok, pop_ok;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign push_ok      = push && !status.full;
   assign pop_ok       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop_ok)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Store incoming bundles
   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: hw/rtl/csvlex_back.sv
// Back part: hands the runs of each queued bundle out one transfer at a time.
`timescale 1ns / 1ps

module csvlex_back import csvlex_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       head,
   input  queue_status_type status,
   input  logic             rsp_pop,
   output logic             queue_pop,
   output logic             rsp_empty,
   output rsp_type          rsp_data
);

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              take;
   logic              last_slot;

   assign rsp_empty = status.empty;
   assign rsp_data  = head.slot[slot_ff];
   assign take      = rsp_pop && !status.empty;
   assign last_slot = (RCNT_W'(slot_ff) + RCNT_W'(1)) == head.count;
   assign queue_pop = take && last_slot;
   assign slot_in   = last_slot ? '0 : slot_ff + SLOT_W'(1);

   // Step through the slots of the head bundle
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (take) begin
         slot_ff <= slot_in;
      end
   end

endmodule

FILE: hw/rtl/csv_cell_style_lexer.sv
// Top level of the CSV cell style lexer: front classifier, bundle queue, result serializer.
//
// Usage:
//   Input queue: drive req_data (text_byte, region_end) and raise req_push; a byte is
//   taken at each clock edge with req_push high and req_full low. A region begins at
//   a line boundary; mark its last byte with region_end to flush all open runs.
//   Result queue: while rsp_empty is low, rsp_data holds the oldest style run
//   (run_length, style_code, run_last); raise rsp_pop to take it.
//   Configuration: csr_we with csr_index 0 writes the separator byte, index 1 writes
//   the header-line flag. Write only while the block is idle.
// Timing:
//   One byte per cycle is taken while the bundle queue has room. A run closed by a byte
//   enters the bundle queue as that byte is taken. One byte closes at most two runs; the
//   serializer hands out one run per cycle while rsp_pop is high, so the queue depth
//   (QUEUE_DEPTH bundles) sets how long the front runs on while the receiver stalls.
//   When the queue is full, req_full rises and input waits; nothing is dropped.
// Reset:
//   Synchronous, active high. Queue empties, scanner returns to line start, separator
//   is comma and the header-line flag is set.
`timescale 1ns / 1ps

module csv_cell_style_lexer import csvlex_pkg::*; #(
   parameter int MAX_REGION_BYTES = DEF_MAX_REGION_BYTES,
   parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic             accept;
   logic             bundle_valid;
   bundle_type       bundle;
   bundle_type       head;
   queue_status_type status;
   logic             queue_pop;

   assign req_full = status.full;
   assign accept   = req_push && !status.full;

   // Classify bytes
   csvlex_front #(
      .MAX_REGION_BYTES(MAX_REGION_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .bundle_valid(bundle_valid),
      .bundle      (bundle)
   );

   // Decouple front and back
   csvlex_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (bundle_valid),
      .push_data(bundle),
      .pop      (queue_pop),
      .head     (head),
      .status   (status)
   );

   // Serialize runs
   csvlex_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .status   (status),
      .rsp_pop  (rsp_pop),
      .queue_pop(queue_pop),
      .rsp_empty(rsp_empty),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hw/rtl/csvlex_checker.sv
// Port-level checks of the CSV cell style lexer and their binding to the top level.
`timescale 1ns / 1ps

module csvlex_checker import csvlex_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // Reset leaves no result and room for input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result waiting or input blocked after reset");

   // A stalled result holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // Every run covers at least one byte
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.run_length != '0)
      else $error("empty run");

   // Line ends are one or two bytes
   a_line_end_len: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.style_code == STYLE_DEFAULT) |->
         (rsp_data.run_length == LEN_W'(1) || rsp_data.run_length == LEN_W'(2)))
      else $error("line end run of wrong length");

   // Separators are single bytes
   a_sep_len: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.style_code == STYLE_SEP) |-> rsp_data.run_length == LEN_W'(1))
      else $error("separator run of wrong length");

endmodule

bind csv_cell_style_lexer csvlex_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_full (req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop  (rsp_pop),
   .rsp_data (rsp_data)
);

FILE: tb/testbench.sv
// Self-checking testbench for the CSV cell style lexer: directed table, random regions,
// run predictor.
`timescale 1ns / 1ps

module testbench;
   import csvlex_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 80;
   localparam int PHASE_ITEMS   = 20;
   localparam int PREDICTED     = -1;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;

   typedef enum logic [2:0] {
      SCAN_LINE, SCAN_CELL, SCAN_QUOTE, SCAN_QEND, SCAN_COMMENT, SCAN_CR
   } scan_mode_type;

   typedef enum logic [2:0] {
      NUM_LEAD, NUM_SIGN, NUM_BODY, NUM_TRAIL, NUM_FAIL
   } num_phase_type;

   // One stimulus byte; a typed-in expectation replaces the predicted runs
   typedef struct {
      logic [7:0]         text_byte;
      logic               region_end;
      int                 fixed_count;
      int                 fixed_len;
      logic [STYLE_W-1:0] fixed_style;
      logic               fixed_last;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_index;
   logic [7:0] csr_wdata;

   // Lexer state as predicted
   logic [7:0]    cfg_sep;
   logic          cfg_doc;
   scan_mode_type lex_mode;
   logic          header_line;
   logic          parity;
   int unsigned   run_len;
   num_phase_type num_phase;
   logic          seen_digit;
   logic          seen_dot;
   logic          fresh;

   rsp_type step_runs[$];
   rsp_type runs_due[$];
   logic [7:0] region_text[$];

   int errors = 0;
   int quiet_cycles = 0;
   int hold_requests = 0;
   bit no_idle = 0;

   stim_row_type directed_rows [0:24] = '{
      '{CHAR_LOW_A, 1'b0, 0,         0, STYLE_DEFAULT, 1'b0},
      '{CHAR_COMMA, 1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_QUOTE, 1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_QUOTE, 1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_QUOTE, 1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_QUOTE, 1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_CR,    1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_LF,    1'b0, 1,         2, STYLE_DEFAULT, 1'b0},
      '{CHAR_HASH,  1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{8'hFF,      1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_LF,    1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_SPACE, 1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_MINUS, 1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{8'h31,      1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_DOT,   1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{8'h35,      1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_TAB,   1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_COMMA, 1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{8'h00,      1'b0, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{CHAR_CR,    1'b1, PREDICTED, 0, STYLE_DEFAULT, 1'b0},
      '{8'h78,      1'b1, 1,         1, STYLE_HEADER,  1'b1},
      '{CHAR_QUOTE, 1'b1, 1,         1, STYLE_QUOTED,  1'b1},
      '{CHAR_HASH,  1'b1, 1,         1, STYLE_COMMENT, 1'b1},
      '{CHAR_LF,    1'b1, 1,         1, STYLE_DEFAULT, 1'b1},
      '{CHAR_CR,    1'b1, 1,         1, STYLE_DEFAULT, 1'b1}
   };

   csv_cell_style_lexer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void add_run(int unsigned len, logic [STYLE_W-1:0] style);
      rsp_type r;
      r.run_length = LEN_W'(len);
      r.style_code = style;
      r.run_last   = 1'b0;
      step_runs.push_back(r);
   endfunction

   function automatic void clear_cell();
      run_len    = 0;
      num_phase  = NUM_LEAD;
      seen_digit = 1'b0;
      seen_dot   = 1'b0;
   endfunction

   function automatic void end_line();
      header_line = 1'b0;
      parity      = 1'b0;
      clear_cell();
   endfunction

   function automatic void start_region();
      lex_mode    = SCAN_LINE;
      header_line = cfg_doc;
      parity      = 1'b0;
      fresh       = 1'b1;
      clear_cell();
   endfunction

   // Saturate at the region bound
   function automatic void bump();
      if (run_len < DEF_MAX_REGION_BYTES) run_len++;
   endfunction

   // Track whether the trimmed cell is still a signed decimal
   function automatic void feed_numeric(logic [7:0] c);
      logic ws;
      logic dig;
      ws  = (c == CHAR_SPACE || c == CHAR_TAB);
      dig = (c >= CHAR_ZERO && c <= CHAR_NINE);
      case (num_phase)
         NUM_LEAD, NUM_SIGN, NUM_BODY: begin
            if (num_phase == NUM_LEAD && ws) begin
               num_phase = NUM_LEAD;
            end else if (num_phase == NUM_LEAD && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
               num_phase = NUM_SIGN;
            end else if (dig) begin
               seen_digit = 1'b1;
               num_phase  = NUM_BODY;
            end else if (c == CHAR_DOT && !seen_dot) begin
               seen_dot  = 1'b1;
               num_phase = NUM_BODY;
            end else if (ws && num_phase == NUM_BODY) begin
               num_phase = NUM_TRAIL;
            end else begin
               num_phase = NUM_FAIL;
            end
         end
         NUM_TRAIL: if (!ws) num_phase = NUM_FAIL;
         default: num_phase = NUM_FAIL;
      endcase
   endfunction

   function automatic void close_cell();
      if (run_len != 0) begin
         if (header_line)
            add_run(run_len, STYLE_HEADER);
         else if ((num_phase == NUM_BODY || num_phase == NUM_TRAIL) && seen_digit)
            add_run(run_len, STYLE_NUMBER);
         else
            add_run(run_len, parity ? STYLE_COL_ODD : STYLE_COL_EVEN);
      end
      clear_cell();
   endfunction

   function automatic void scan_byte(logic [7:0] c);
      if (lex_mode == SCAN_QUOTE) begin
         bump();
         if (c == CHAR_QUOTE) lex_mode = SCAN_QEND;
         return;
      end
      // A second quote is an escape; anything else closes the field
      if (lex_mode == SCAN_QEND) begin
         if (c == CHAR_QUOTE) begin
            bump();
            lex_mode = SCAN_QUOTE;
            return;
         end
         add_run(run_len, STYLE_QUOTED);
         clear_cell();
         lex_mode = SCAN_CELL;
      end
      if (lex_mode == SCAN_COMMENT) begin
         if (c == CHAR_LF || c == CHAR_CR) begin
            add_run(run_len, STYLE_COMMENT);
            end_line();
            if (c == CHAR_LF) begin
               add_run(1, STYLE_DEFAULT);
               lex_mode = SCAN_LINE;
            end else begin
               lex_mode = SCAN_CR;
            end
         end else begin
            bump();
         end
         return;
      end
      // Merge CR LF into one line end
      if (lex_mode == SCAN_CR) begin
         if (c == CHAR_LF) begin
            add_run(2, STYLE_DEFAULT);
            lex_mode = SCAN_LINE;
            return;
         end
         add_run(1, STYLE_DEFAULT);
         lex_mode = SCAN_LINE;
      end
      if (lex_mode == SCAN_LINE && c == CHAR_HASH) begin
         lex_mode = SCAN_COMMENT;
         run_len  = 1;
         return;
      end
      if (c == CHAR_QUOTE) begin
         close_cell();
         run_len  = 1;
         lex_mode = SCAN_QUOTE;
      end else if (c == cfg_sep) begin
         close_cell();
         add_run(1, STYLE_SEP);
         parity = ~parity;
         if (!(lex_mode == SCAN_LINE && (c == CHAR_LF || c == CHAR_CR))) lex_mode = SCAN_CELL;
      end else if (c == CHAR_LF) begin
         close_cell();
         add_run(1, STYLE_DEFAULT);
         end_line();
         lex_mode = SCAN_LINE;
      end else if (c == CHAR_CR) begin
         close_cell();
         end_line();
         lex_mode = SCAN_CR;
      end else begin
         bump();
         feed_numeric(c);
         lex_mode = SCAN_CELL;
      end
   endfunction

   // Work out the runs one accepted byte closes
   function automatic void predict_item(logic [7:0] c, logic last);
      rsp_type r;
      step_runs.delete();
      fresh = 1'b0;
      scan_byte(c);
      if (last) begin
         case (lex_mode)
            SCAN_QUOTE, SCAN_QEND: if (run_len != 0) add_run(run_len, STYLE_QUOTED);
            SCAN_COMMENT: if (run_len != 0) add_run(run_len, STYLE_COMMENT);
            SCAN_CR: add_run(1, STYLE_DEFAULT);
            default: close_cell();
         endcase
         if (step_runs.size() > 0) begin
            r = step_runs.pop_back();
            r.run_last = 1'b1;
            step_runs.push_back(r);
         end
         start_region();
      end
   endfunction

   function automatic void apply_csr(logic idx, logic [7:0] val);
      if (idx == CSR_SEPARATOR_CHAR) begin
         cfg_sep = val;
      end else begin
         cfg_doc = val[0];
         if (fresh) header_line = cfg_doc;
      end
   endfunction

   // ---------------------------------------------------------------- region text

   function automatic void put(logic [7:0] c);
      region_text.push_back(c);
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: c = CHAR_LOW_A + 8'($urandom_range(0, 25));
            4, 5:       c = CHAR_ZERO + 8'($urandom_range(0, 9));
            6:          c = CHAR_SPACE;
            default:    c = 8'($urandom_range(0, 255));
         endcase
      end while (c == CHAR_QUOTE || c == cfg_sep || c == CHAR_LF || c == CHAR_CR);
      return c;
   endfunction

   function automatic void put_blanks();
      repeat ($urandom_range(0, 2)) put($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endfunction

   // Mostly well-formed decimals, now and then spoiled
   function automatic void put_number();
      int ndig;
      int dot_at;
      put_blanks();
      case ($urandom_range(0, 3))
         0: put(CHAR_MINUS);
         1: put(CHAR_PLUS);
         default: ;
      endcase
      ndig   = $urandom_range(0, 4);
      dot_at = $urandom_range(0, 6);
      for (int i = 0; i < ndig; i++) begin
         if (i == dot_at) put(CHAR_DOT);
         put(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      if (dot_at == ndig) put(CHAR_DOT);
      case ($urandom_range(0, 9))
         0: put(plain_byte());
         1: put(CHAR_DOT);
         2: put(CHAR_MINUS);
         default: ;
      endcase
      put_blanks();
   endfunction

   function automatic void put_quoted();
      put(CHAR_QUOTE);
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 7))
            0: begin
               put(CHAR_QUOTE);
               put(CHAR_QUOTE);
            end
            1: put($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            2: put(cfg_sep);
            default: put(plain_byte());
         endcase
      end
      if ($urandom_range(0, 9) != 0) put(CHAR_QUOTE);
      if ($urandom_range(0, 5) == 0) put(plain_byte());
   endfunction

   function automatic void put_line();
      int cells;
      case ($urandom_range(0, 9))
         0: begin
            put(CHAR_HASH);
            repeat ($urandom_range(0, 6)) put(plain_byte());
         end
         1: repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
         default: begin
            cells = $urandom_range(1, 4);
            for (int k = 0; k < cells; k++) begin
               if (k != 0) put(cfg_sep);
               case ($urandom_range(0, 5))
                  0, 1: put_number();
                  2: put_quoted();
                  3: ;
                  default: repeat ($urandom_range(1, 5)) put(plain_byte());
               endcase
            end
         end
      endcase
      case ($urandom_range(0, 3))
         0: put(CHAR_CR);
         1: begin
            put(CHAR_CR);
            put(CHAR_LF);
         end
         default: put(CHAR_LF);
      endcase
   endfunction

   // Build a few lines; sometimes cut the region mid-line
   function automatic void build_region();
      int keep;
      region_text.delete();
      repeat ($urandom_range(1, 3)) put_line();
      if ($urandom_range(0, 3) == 0) begin
         keep = $urandom_range(1, region_text.size());
         while (region_text.size() > keep) void'(region_text.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one byte, wait for the transfer, then queue its runs
   task automatic take_item(input stim_row_type row);
      req_type item;
      rsp_type typed_run;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      item.text_byte  = row.text_byte;
      item.region_end = row.region_end;
      req_push <= 1'b1;
      req_data <= item;
      @(negedge clock);
      while (req_full) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      predict_item(row.text_byte, row.region_end);
      if (row.fixed_count == PREDICTED) begin
         foreach (step_runs[k]) runs_due.push_back(step_runs[k]);
      end else if (row.fixed_count == 1) begin
         typed_run.run_length = LEN_W'(row.fixed_len);
         typed_run.style_code = row.fixed_style;
         typed_run.run_last   = row.fixed_last;
         runs_due.push_back(typed_run);
      end
   endtask

   // Drop the request and let every expected run drain
   task automatic wait_idle();
      req_push <= 1'b0;
      while (runs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] sep, input logic doc, input bit split,
                            input bit squeeze);
      int sent;
      int cut;
      stim_row_type item_row;
      wait_idle();
      write_csr(CSR_SEPARATOR_CHAR, sep);
      write_csr(CSR_REGION_DOC, {7'd0, doc});
      if (squeeze) hold_requests++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         do build_region(); while (split && sent == 0 && region_text.size() < 2);
         cut = (split && sent == 0) ? region_text.size() / 2 : -1;
         for (int i = 0; i < region_text.size(); i++) begin
            // Flip the header flag while a region is open
            if (i == cut) begin
               wait_idle();
               write_csr(CSR_REGION_DOC, {7'd0, ~cfg_doc});
            end
            item_row = '{region_text[i], i == region_text.size() - 1, PREDICTED, 0,
                         STYLE_DEFAULT, 1'b0};
            take_item(item_row);
         end
         sent += region_text.size();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_SEPARATOR_CHAR;
      csr_wdata <= '0;
      cfg_sep = DEF_SEPARATOR;
      cfg_doc = DEF_REGION_DOC;
      start_region();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) take_item(directed_rows[i]);

      run_phase(CHAR_COMMA, 1'b1, 1'b0, 1'b0);
      run_phase(CHAR_TAB,   1'b0, 1'b0, 1'b1);
      run_phase(8'h00,      1'b1, 1'b1, 1'b0);
      run_phase(8'hFF,      1'b0, 1'b0, 1'b0);
      run_phase(CHAR_LF,    1'b1, 1'b0, 1'b0);
      run_phase(CHAR_CR,    1'b0, 1'b1, 1'b0);
      run_phase(CHAR_HASH,  1'b1, 1'b0, 1'b0);
      run_phase(CHAR_QUOTE, 1'b0, 1'b0, 1'b0);
      run_phase(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      run_phase(CHAR_SEMI,  1'b0, 1'b0, 1'b1);
      no_idle = 1;
      run_phase(CHAR_COMMA, 1'b1, 1'b0, 1'b0);

      wait_idle();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Result side: random pop stalls, plus a long hold-off on request
   initial begin : pop_driver
      int holds_done;
      int gap;
      holds_done = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (holds_done != hold_requests) begin
            holds_done++;
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            rsp_pop <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Check each run transfer against the oldest expectation; watch for a hang
   always @(negedge clock) begin : run_check
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (runs_due.size() == 0) begin
            $error("unexpected run: run_length %0d style_code %0d run_last %0d",
                   rsp_data.run_length, rsp_data.style_code, rsp_data.run_last);
            errors++;
         end else begin
            want = runs_due.pop_front();
            if (rsp_data.run_length !== want.run_length) begin
               $error("run_length: expected %0d, actual %0d", want.run_length,
                      rsp_data.run_length);
               errors++;
            end
            if (rsp_data.style_code !== want.style_code) begin
               $error("style_code: expected %0d, actual %0d", want.style_code,
                      rsp_data.style_code);
               errors++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $error("run_last: expected %0d, actual %0d", want.run_last,
                      rsp_data.run_last);
               errors++;
            end
         end
      end
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
